@@ rtl/core/fpt_pkg.sv @@
// fpt_pkg: shared types and constants for the fifo page translate unit
// used by fpt_cell and fifo_page_translate_unit, no dependencies
`default_nettype none

package fpt_pkg;

   // parameter defaults
   localparam int unsigned MAX_FRAMES_DEF = 32;
   localparam int unsigned ADDR_BITS_DEF  = 16;
   localparam int unsigned FRAME_W_DEF    = (MAX_FRAMES_DEF > 1) ? $clog2(MAX_FRAMES_DEF) : 1;

   // register and field widths
   localparam int unsigned PAGE_BITS_W   = 4;
   localparam int unsigned FRAME_COUNT_W = 6;
   localparam int unsigned CSR_DATA_W    = 6;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned PHYS_W        = 20;
   localparam int unsigned FAULT_W       = 32;
   localparam int unsigned RSP_FIELDS_W  = PHYS_W + 1 + FAULT_W;
   localparam int unsigned RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   // register reset values
   localparam logic [PAGE_BITS_W-1:0]   PAGE_BITS_RESET   = 4'd8;
   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 6'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAGE_BITS   = 1'b0,
      CSR_FRAME_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic flush;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/fpt_cell.sv @@
// fpt_cell: one entry of the resident page row, tag compare and shift stage
// depends on fpt_pkg
`default_nettype none

module fpt_cell #(
   parameter int unsigned ADDR_BITS = fpt_pkg::ADDR_BITS_DEF,
   parameter int unsigned FRAME_W   = fpt_pkg::FRAME_W_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fpt_pkg::cell_ctrl_type ctrl,
   input  wire logic                  valid_in,
   input  wire logic [ADDR_BITS-1:0]  page_in,
   input  wire logic [FRAME_W-1:0]    frame_in,
   input  wire logic [ADDR_BITS-1:0]  lookup_page,
   output logic                       valid_out,
   output logic [ADDR_BITS-1:0]       page_out,
   output logic [FRAME_W-1:0]         frame_out,
   output logic                       hit
);

   logic                 valid_ff;
   logic [ADDR_BITS-1:0] page_ff;
   logic [FRAME_W-1:0]   frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.flush) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         page_ff  <= page_in;
         frame_ff <= frame_in;
      end
   end

   assign valid_out = valid_ff;
   assign page_out  = page_ff;
   assign frame_out = frame_ff;
   assign hit       = valid_ff && (page_ff == lookup_page);

endmodule

`default_nettype wire

@@ rtl/core/fifo_page_translate_unit.sv @@
// fifo_page_translate_unit: logical to physical translation with fifo replacement
// a req word is held in the input register until the lookup writes it to the rsp register
// a new word is taken only once the last one is written to the rsp register
// the rsp register frees the input side as soon as a result is written into it
// reset: synchronous, active high; clears all cell valids, counters, control regs to defaults
// depends on fpt_pkg and fpt_cell
`default_nettype none

module fifo_page_translate_unit #(
   parameter int unsigned MAX_FRAMES = fpt_pkg::MAX_FRAMES_DEF,
   parameter int unsigned ADDR_BITS  = fpt_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request stream
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((ADDR_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // logical_address, zero pad
   input  wire logic                                   req_tlast,  // is_last
   // response stream
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // physical_address[19:0], page_fault[20], fault_total[52:21], zero pad
   output logic [fpt_pkg::RSP_DATA_W-1:0]              rsp_tdata,
   output logic                                        rsp_tlast,  // last_out
   // config write port
   input  wire logic                                   csr_we,
   input  wire logic [fpt_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [fpt_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int unsigned FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);
   localparam int unsigned CMP_W   = (CNT_W > fpt_pkg::FRAME_COUNT_W) ? CNT_W
                                                                      : fpt_pkg::FRAME_COUNT_W;
   localparam int unsigned WIDE_W  = ADDR_BITS + FRAME_W + 16;
   localparam int unsigned PAD_W   = fpt_pkg::RSP_DATA_W - fpt_pkg::RSP_FIELDS_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

   // control state
   fpt_pkg::state_type                  state_ff, state_in;
   logic [fpt_pkg::PAGE_BITS_W-1:0]     page_bits_ff, page_bits_in;
   logic [fpt_pkg::FRAME_COUNT_W-1:0]   frame_count_ff, frame_count_in;
   logic [CNT_W-1:0]                    frames_used_ff, frames_used_in;
   logic [fpt_pkg::FAULT_W-1:0]         fault_ff, fault_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ADDR_BITS-1:0]                addr_ff;
   logic                                last_ff;
   logic [fpt_pkg::PHYS_W-1:0]          rsp_phys_ff;
   logic                                rsp_fault_ff;
   logic [fpt_pkg::FAULT_W-1:0]         rsp_total_ff;
   logic                                rsp_last_ff;

   // lookup datapath
   logic [CMP_W-1:0]                    fc_ext;
   logic [CNT_W-1:0]                    n_act;
   logic [ADDR_BITS-1:0]                page;
   logic [ADDR_BITS-1:0]                offset;
   logic [MAX_FRAMES-1:0]               hit_vec;
   logic [MAX_FRAMES-1:0]               valid_vec;
   logic [FRAME_W-1:0]                  cell_frame [MAX_FRAMES];
   logic [ADDR_BITS-1:0]                cell_page  [MAX_FRAMES];
   logic                                hit_any;
   logic [FRAME_W-1:0]                  hit_frame;
   logic                                fill;
   logic [FRAME_W-1:0]                  victim_idx;
   logic [FRAME_W-1:0]                  new_frame;
   logic [FRAME_W-1:0]                  frame_sel;
   logic [WIDE_W-1:0]                   phys_wide;
   logic [fpt_pkg::FAULT_W-1:0]         fault_next;
   logic                                do_look;
   logic                                req_accept;
   fpt_pkg::cell_ctrl_type              cell_ctrl;

   // frames in use: zero acts as one, clipped to the row length
   always_comb begin
      fc_ext = CMP_W'(frame_count_ff);
      if (frame_count_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (fc_ext > MAX_CMP) begin
         n_act = MAX_CNT;
      end else begin
         n_act = CNT_W'(fc_ext);
      end
   end

   // split the held address into page number and offset
   assign page   = addr_ff >> page_bits_ff;
   assign offset = addr_ff & ~({ADDR_BITS{1'b1}} << page_bits_ff);

   // row of cells: newest load at cell 0, oldest at cell n_act-1
   genvar k;
   generate
      for (k = 0; k < MAX_FRAMES; k++) begin : g_cell
         logic                 vin;
         logic [ADDR_BITS-1:0] pin;
         logic [FRAME_W-1:0]   fin;
         if (k == 0) begin : g_head
            assign vin = 1'b1;
            assign pin = page;
            assign fin = new_frame;
         end else begin : g_body
            // entries pushed beyond the active frame count drop out
            assign vin = valid_vec[k-1] && (CNT_W'(k) < n_act);
            assign pin = cell_page[k-1];
            assign fin = cell_frame[k-1];
         end
         fpt_cell #(
            .ADDR_BITS (ADDR_BITS),
            .FRAME_W   (FRAME_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .valid_in    (vin),
            .page_in     (pin),
            .frame_in    (fin),
            .lookup_page (page),
            .valid_out   (valid_vec[k]),
            .page_out    (cell_page[k]),
            .frame_out   (cell_frame[k]),
            .hit         (hit_vec[k])
         );
      end
   endgenerate

   // resident pages are unique, so an or over the matching cells gives the frame
   always_comb begin
      hit_frame = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         hit_frame = hit_frame | (cell_frame[i] & {FRAME_W{hit_vec[i]}});
      end
   end

   assign hit_any    = |hit_vec;
   assign fill       = frames_used_ff < n_act;
   assign victim_idx = FRAME_W'(n_act - CNT_W'(1));
   // free frames go out in ascending order, then the oldest load is reused
   assign new_frame  = fill ? FRAME_W'(frames_used_ff) : cell_frame[victim_idx];
   assign frame_sel  = hit_any ? hit_frame : new_frame;
   assign phys_wide  = (WIDE_W'(frame_sel) << page_bits_ff) + WIDE_W'(offset);
   assign fault_next = (fault_ff != '1) ? fault_ff + fpt_pkg::FAULT_W'(1) : fault_ff;

   // lookup completes once the output register is free or being drained
   assign do_look    = (state_ff == fpt_pkg::ST_LOOK) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == fpt_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // a config write or the end of a sequence empties the row
   assign cell_ctrl.shift = do_look && !hit_any;
   assign cell_ctrl.flush = csr_we || (do_look && last_ff);

   always_comb begin
      state_in       = state_ff;
      page_bits_in   = page_bits_ff;
      frame_count_in = frame_count_ff;
      frames_used_in = frames_used_ff;
      fault_in       = fault_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         fpt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = fpt_pkg::ST_LOOK;
            end
         end
         fpt_pkg::ST_LOOK: begin
            if (do_look) begin
               state_in     = fpt_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (!hit_any) begin
                  fault_in = fault_next;
                  if (fill) begin
                     frames_used_in = frames_used_ff + CNT_W'(1);
                  end
               end
               // end of sequence: fresh table and fault count
               if (last_ff) begin
                  frames_used_in = '0;
                  fault_in       = '0;
               end
            end
         end
         default: begin
            state_in = fpt_pkg::ST_IDLE;
         end
      endcase
      if (csr_we) begin
         frames_used_in = '0;
         case (fpt_pkg::csr_index_type'(csr_index))
            fpt_pkg::CSR_PAGE_BITS: begin
               page_bits_in = csr_wdata[fpt_pkg::PAGE_BITS_W-1:0];
            end
            fpt_pkg::CSR_FRAME_COUNT: begin
               frame_count_in = csr_wdata[fpt_pkg::FRAME_COUNT_W-1:0];
            end
            default: begin
               page_bits_in = page_bits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fpt_pkg::ST_IDLE;
         page_bits_ff   <= fpt_pkg::PAGE_BITS_RESET;
         frame_count_ff <= fpt_pkg::FRAME_COUNT_RESET;
         frames_used_ff <= '0;
         fault_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         page_bits_ff   <= page_bits_in;
         frame_count_ff <= frame_count_in;
         frames_used_ff <= frames_used_in;
         fault_ff       <= fault_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff <= req_tdata[ADDR_BITS-1:0];
         last_ff <= req_tlast;
      end
   end

   // result word capture
   always_ff @(posedge clock) begin
      if (do_look) begin
         rsp_phys_ff  <= phys_wide[fpt_pkg::PHYS_W-1:0];
         rsp_fault_ff <= !hit_any;
         rsp_total_ff <= hit_any ? fault_ff : fault_next;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_total_ff, rsp_fault_ff, rsp_phys_ff};
   assign rsp_tlast  = rsp_last_ff;

   // at most one cell can hold a given page
   a_unique_hit : assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell matches the page");

   // fill count never passes the active frame count
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      frames_used_ff <= n_act)
      else $error("frames_used beyond active frame count");

   // an accepted word moves the unit into lookup
   a_accept_look : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == fpt_pkg::ST_LOOK))
      else $error("accepted word not in lookup");

   // a config write leaves an empty table
   a_cfg_flush : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (frames_used_ff == '0) && (valid_vec == '0))
      else $error("table not flushed after config write");

endmodule

`default_nettype wire
